// ----- hdl/mbrs_pkg.sv -----
// ----------------------------------------------------------------------------
// mbrs_pkg
// Shared types and constants of the RTU slave responder: payload words,
// sequencer states, reply kinds, function and exception codes.
// ----------------------------------------------------------------------------
package mbrs_pkg;

   localparam int NUM_INPUT_REGS_DEFAULT = 16;
   localparam int REG_INDEX_W            = 4;
   localparam int BYTE_CNT_W             = 6;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic        CMD_REQUEST         = 1'b0;
   localparam logic        CMD_REG_UPDATE      = 1'b1;
   localparam logic [7:0]  FC_READ_INPUT       = 8'h04;
   localparam logic [7:0]  FC_WRITE_SINGLE     = 8'h06;
   localparam logic [7:0]  EXC_FLAG            = 8'h80;
   localparam logic [7:0]  EXC_ILLEGAL_ADDRESS = 8'h02;
   localparam logic [7:0]  EXC_ILLEGAL_VALUE   = 8'h03;
   localparam logic [15:0] ID_REGISTER         = 16'h0001;
   localparam logic [15:0] READ_LIMIT          = 16'd125;
   localparam logic [15:0] ID_LIMIT            = 16'd247;
   localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'h01;

   typedef logic [BYTE_CNT_W-1:0] byte_cnt_type;

   localparam byte_cnt_type LEN_EXCEPTION = 6'd3;
   localparam byte_cnt_type LEN_WRITE     = 6'd6;
   localparam byte_cnt_type LEN_HEADER    = 6'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DATA,
      ST_CRC_LO,
      ST_CRC_HI
   } state_type;

   typedef enum logic [1:0] {
      REPLY_READ,
      REPLY_WRITE,
      REPLY_EXCEPTION
   } reply_type;

   typedef struct packed {
      logic                   command;
      logic [7:0]             frame_address;
      logic [7:0]             func_code;
      logic [15:0]            word_address;
      logic [15:0]            word_value;
      logic [REG_INDEX_W-1:0] reg_index;
      logic [15:0]            reg_value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
      logic [7:0] pending_slave_address;
   } rsp_payload_type;

endpackage

// ----- hdl/mbrs_crc16.sv -----
// ----------------------------------------------------------------------------
// mbrs_crc16
// CRC-16 update over one byte, reflected polynomial, LSB first.
// ----------------------------------------------------------------------------
module mbrs_crc16 (
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);

   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {8'h00, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ mbrs_pkg::CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

// ----- hdl/mbrs_regfile.sv -----
// ----------------------------------------------------------------------------
// mbrs_regfile
// Input register store: local writes with range check, one read port.
// ----------------------------------------------------------------------------
module mbrs_regfile #(
   parameter int NUM_INPUT_REGS = mbrs_pkg::NUM_INPUT_REGS_DEFAULT,
   parameter int IDX_W          = (NUM_INPUT_REGS > 1) ? $clog2(NUM_INPUT_REGS) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [mbrs_pkg::REG_INDEX_W-1:0]   wr_index,
   input  logic [15:0]                        wr_data,
   input  logic [IDX_W-1:0]                   rd_index,
   output logic [15:0]                        rd_data
);

   logic [15:0] regs_ff [NUM_INPUT_REGS];
   logic [15:0] regs_in [NUM_INPUT_REGS];

   always_comb begin
      for (int i = 0; i < NUM_INPUT_REGS; i++) begin
         regs_in[i] = regs_ff[i];
         if (wr_en && (32'(wr_index) == i)) begin
            regs_in[i] = wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_INPUT_REGS; i++) begin
         if (reset) begin
            regs_ff[i] <= '0;
         end else begin
            regs_ff[i] <= regs_in[i];
         end
      end
   end

   always_comb begin
      rd_data = '0;
      for (int i = 0; i < NUM_INPUT_REGS; i++) begin
         if (32'(rd_index) == i) begin
            rd_data = regs_ff[i];
         end
      end
   end

endmodule

// ----- hdl/modbus_rtu_slave_responder_core.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_slave_responder_core
// RTU slave reply generator with input register store and CRC-16 trailer.
// ----------------------------------------------------------------------------
// A word is accepted on the edge where start is high and busy is low. With
// command set it updates one input register and produces nothing. Otherwise
// a request for this slave address is decoded in the accept cycle and busy
// rises. The reply leaves one byte per cycle on rsp_data with rsp_valid high
// for exactly one cycle per byte; the last CRC byte carries last_byte. Busy
// holds while the sequencer, with one shared CRC byte unit, walks ST_DATA
// over the message bytes (3 for an exception, 6 for a write echo, 3 + 2*count
// for a register read), then ST_CRC_LO and ST_CRC_HI. Requests with no reply
// leave busy low, so the next word is taken in the next cycle. The receiver
// cannot stall. csr_write_enable loads the slave address; the user must load
// it only while the block is idle, as the block does not enforce this. Reset
// sets the slave and pending address to 1 and clears all input registers.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_responder_core #(
   parameter int NUM_INPUT_REGS = mbrs_pkg::NUM_INPUT_REGS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  mbrs_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   output mbrs_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_write_enable,
   input  logic [7:0]                csr_write_data
);

   localparam int IDX_W = (NUM_INPUT_REGS > 1) ? $clog2(NUM_INPUT_REGS) : 1;
   localparam int CW    = mbrs_pkg::BYTE_CNT_W;

   mbrs_pkg::state_type       state_ff, state_in;
   mbrs_pkg::reply_type       kind_ff, kind_in;
   mbrs_pkg::byte_cnt_type    pos_ff, pos_in;
   mbrs_pkg::byte_cnt_type    len_ff, len_in;
   logic [7:0]                slave_ff, slave_in;
   logic [7:0]                pending_ff, pending_in;
   logic [7:0]                addr_ff, addr_in;
   logic [7:0]                fc_ff, fc_in;
   logic [7:0]                code_ff, code_in;
   logic [15:0]               waddr_ff, waddr_in;
   logic [15:0]               wval_ff, wval_in;
   logic [15:0]               crc_ff, crc_in;
   logic [IDX_W-1:0]          ptr_ff, ptr_in;
   logic                      hi_ff, hi_in;
   logic                      valid_ff, valid_in;
   mbrs_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic        rf_wr_en;
   logic [15:0] rf_rd_data;
   logic [7:0]  data_byte;
   logic [15:0] crc_next;
   logic        accept;

   mbrs_regfile #(
      .NUM_INPUT_REGS (NUM_INPUT_REGS),
      .IDX_W          (IDX_W)
   ) u_regfile (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (rf_wr_en),
      .wr_index (req_data.reg_index),
      .wr_data  (req_data.reg_value),
      .rd_index (ptr_ff),
      .rd_data  (rf_rd_data)
   );

   mbrs_crc16 u_crc (
      .crc_cur   (crc_ff),
      .data_byte (data_byte),
      .crc_next  (crc_next)
   );

   assign busy      = (state_ff != mbrs_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   // message byte at the current position
   always_comb begin
      data_byte = addr_ff;
      unique case (kind_ff)
         mbrs_pkg::REPLY_EXCEPTION: begin
            priority if (pos_ff == CW'(0)) data_byte = addr_ff;
            else if (pos_ff == CW'(1))     data_byte = fc_ff | mbrs_pkg::EXC_FLAG;
            else                           data_byte = code_ff;
         end
         mbrs_pkg::REPLY_WRITE: begin
            priority if (pos_ff == CW'(0)) data_byte = addr_ff;
            else if (pos_ff == CW'(1))     data_byte = fc_ff;
            else if (pos_ff == CW'(2))     data_byte = waddr_ff[15:8];
            else if (pos_ff == CW'(3))     data_byte = waddr_ff[7:0];
            else if (pos_ff == CW'(4))     data_byte = wval_ff[15:8];
            else                           data_byte = wval_ff[7:0];
         end
         mbrs_pkg::REPLY_READ: begin
            priority if (pos_ff == CW'(0)) data_byte = addr_ff;
            else if (pos_ff == CW'(1))     data_byte = fc_ff;
            else if (pos_ff == CW'(2))     data_byte = {wval_ff[6:0], 1'b0};
            else if (hi_ff)                data_byte = rf_rd_data[15:8];
            else                           data_byte = rf_rd_data[7:0];
         end
         default: data_byte = addr_ff;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      slave_in   = slave_ff;
      pending_in = pending_ff;
      addr_in    = addr_ff;
      fc_in      = fc_ff;
      code_in    = code_ff;
      waddr_in   = waddr_ff;
      wval_in    = wval_ff;
      crc_in     = crc_ff;
      ptr_in     = ptr_ff;
      hi_in      = hi_ff;
      valid_in   = 1'b0;
      rsp_in     = rsp_ff;
      rf_wr_en   = 1'b0;

      if (csr_write_enable) begin
         slave_in = csr_write_data;
      end

      unique case (state_ff)
         mbrs_pkg::ST_IDLE: begin
            if (accept) begin
               addr_in  = req_data.frame_address;
               fc_in    = req_data.func_code;
               waddr_in = req_data.word_address;
               wval_in  = req_data.word_value;
               pos_in   = '0;
               hi_in    = 1'b1;
               ptr_in   = req_data.word_address[IDX_W-1:0];
               crc_in   = mbrs_pkg::CRC_INIT;
               if (req_data.command == mbrs_pkg::CMD_REG_UPDATE) begin
                  rf_wr_en = 1'b1;
               end else if (req_data.frame_address == slave_ff) begin
                  if (req_data.func_code == mbrs_pkg::FC_READ_INPUT) begin
                     state_in = mbrs_pkg::ST_DATA;
                     if ((req_data.word_value == 16'd0) ||
                         (req_data.word_value > mbrs_pkg::READ_LIMIT)) begin
                        kind_in = mbrs_pkg::REPLY_EXCEPTION;
                        code_in = mbrs_pkg::EXC_ILLEGAL_VALUE;
                        len_in  = mbrs_pkg::LEN_EXCEPTION;
                     end else if (({1'b0, req_data.word_address} +
                                   {1'b0, req_data.word_value}) >
                                  17'(NUM_INPUT_REGS)) begin
                        kind_in = mbrs_pkg::REPLY_EXCEPTION;
                        code_in = mbrs_pkg::EXC_ILLEGAL_ADDRESS;
                        len_in  = mbrs_pkg::LEN_EXCEPTION;
                     end else begin
                        kind_in = mbrs_pkg::REPLY_READ;
                        len_in  = {req_data.word_value[CW-2:0], 1'b0} +
                                  mbrs_pkg::LEN_HEADER;
                     end
                  end else if (req_data.func_code == mbrs_pkg::FC_WRITE_SINGLE) begin
                     state_in = mbrs_pkg::ST_DATA;
                     if (req_data.word_address != mbrs_pkg::ID_REGISTER) begin
                        kind_in = mbrs_pkg::REPLY_EXCEPTION;
                        code_in = mbrs_pkg::EXC_ILLEGAL_ADDRESS;
                        len_in  = mbrs_pkg::LEN_EXCEPTION;
                     end else if ((req_data.word_value == 16'd0) ||
                                  (req_data.word_value > mbrs_pkg::ID_LIMIT)) begin
                        kind_in = mbrs_pkg::REPLY_EXCEPTION;
                        code_in = mbrs_pkg::EXC_ILLEGAL_VALUE;
                        len_in  = mbrs_pkg::LEN_EXCEPTION;
                     end else begin
                        kind_in    = mbrs_pkg::REPLY_WRITE;
                        len_in     = mbrs_pkg::LEN_WRITE;
                        pending_in = req_data.word_value[7:0];
                     end
                  end
               end
            end
         end
         mbrs_pkg::ST_DATA: begin
            valid_in = 1'b1;
            rsp_in   = '{tx_byte: data_byte, last_byte: 1'b0,
                         pending_slave_address: pending_ff};
            crc_in   = crc_next;
            pos_in   = pos_ff + CW'(1);
            if ((kind_ff == mbrs_pkg::REPLY_READ) && (pos_ff >= mbrs_pkg::LEN_HEADER)) begin
               hi_in = !hi_ff;
               if (!hi_ff) begin
                  ptr_in = ptr_ff + IDX_W'(1);
               end
            end
            if (pos_ff == (len_ff - CW'(1))) begin
               state_in = mbrs_pkg::ST_CRC_LO;
            end
         end
         mbrs_pkg::ST_CRC_LO: begin
            valid_in = 1'b1;
            rsp_in   = '{tx_byte: crc_ff[7:0], last_byte: 1'b0,
                         pending_slave_address: pending_ff};
            state_in = mbrs_pkg::ST_CRC_HI;
         end
         mbrs_pkg::ST_CRC_HI: begin
            valid_in = 1'b1;
            rsp_in   = '{tx_byte: crc_ff[15:8], last_byte: 1'b1,
                         pending_slave_address: pending_ff};
            state_in = mbrs_pkg::ST_IDLE;
         end
         default: state_in = mbrs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mbrs_pkg::ST_IDLE;
         valid_ff   <= 1'b0;
         slave_ff   <= mbrs_pkg::SLAVE_ADDRESS_RESET;
         pending_ff <= mbrs_pkg::SLAVE_ADDRESS_RESET;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         slave_ff   <= slave_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      pos_ff   <= pos_in;
      len_ff   <= len_in;
      addr_ff  <= addr_in;
      fc_ff    <= fc_in;
      code_ff  <= code_in;
      waddr_ff <= waddr_in;
      wval_ff  <= wval_in;
      crc_ff   <= crc_in;
      ptr_ff   <= ptr_in;
      hi_ff    <= hi_in;
      rsp_ff   <= rsp_in;
   end

`ifndef SYNTHESIS
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_byte |=> !rsp_valid)
      else $error("reply byte directly after last byte");

   a_bytes_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_byte |=> rsp_valid)
      else $error("gap inside reply");

   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid)
      else $error("reply byte in cycle after accept");

   a_crc_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == mbrs_pkg::ST_CRC_LO |=> state_ff == mbrs_pkg::ST_CRC_HI)
      else $error("CRC high byte not after low byte");
`endif

endmodule
